>>> hdl/w2dhb_pkg.sv
// Shared types and constants of the weighted 2-D histogram binner.
`default_nettype none
package w2dhb_pkg;

  typedef logic signed [31:0] q16_t;

  // Item kinds carried in s_tuser
  localparam logic [1:0] OP_BIN   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes
  localparam int          CFG_ADDR_W      = 3;
  localparam logic [2:0]  REG_ORIGIN_X    = 3'd0;
  localparam logic [2:0]  REG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0]  REG_SCALE_X     = 3'd2;
  localparam logic [2:0]  REG_SCALE_Y     = 3'd3;
  localparam logic [2:0]  REG_IMAGE_W     = 3'd4;
  localparam logic [2:0]  REG_IMAGE_H     = 3'd5;
  localparam logic [2:0]  REG_MAGIC_MODE  = 3'd6;
  localparam logic [2:0]  REG_USE_WEIGHT  = 3'd7;

  localparam int S_TDATA_W = 144;
  localparam int M_TDATA_W = 48;

  // Q16.16 constants
  localparam q16_t ONE_Q16     = 32'sh0001_0000;
  localparam q16_t MARKER_CODE = 32'sh8000_0000;
  localparam q16_t SUM_MAX     = 32'sh7FFF_FFFF;
  localparam q16_t SUM_MIN     = 32'sh8000_0001;

  localparam logic [8:0] IMAGE_SIZE_RST = 9'd256;

endpackage
`default_nettype wire

>>> hdl/w2dhb_axis_map.sv
// Coordinate to bin index mapper for one axis: subtract, split multiply, floor and range check.
`default_nettype none
module w2dhb_axis_map import w2dhb_pkg::*; #(
  parameter int IDX_W = 8,
  parameter int SZ_W  = 9
) (
  input  wire logic             clk,
  input  wire q16_t             coord,
  input  wire q16_t             origin,
  input  wire q16_t             scale,
  input  wire logic [SZ_W-1:0]  size,
  output logic                  in_range,
  output logic [IDX_W-1:0]      index,
  output logic [7:0]            low8
);

  logic signed [32:0] diff;
  logic signed [48:0] pp_lo;
  logic signed [48:0] pp_hi;
  logic signed [64:0] prod;
  logic signed [32:0] floor_v;

  // Three register stages; the caller holds coord steady through all three
  always_ff @(posedge clk) begin
    diff  <= {coord[31], coord} - {origin[31], origin};
    pp_lo <= $signed({1'b0, diff[15:0]}) * scale;
    pp_hi <= $signed(diff[32:16]) * scale;
  end

  always_comb begin
    prod    = $signed({pp_hi, 16'b0}) + $signed({{16{pp_lo[48]}}, pp_lo});
    floor_v = prod[64:32];
  end

  always_ff @(posedge clk) begin
    in_range <= !floor_v[32] && (floor_v[31:0] < 32'(size));
    index    <= floor_v[IDX_W-1:0];
    low8     <= floor_v[7:0];
  end

endmodule
`default_nettype wire

>>> hdl/w2dhb_pixel_ram.sv
// Pixel store: one write port, one read port with registered read data.
`default_nettype none
module w2dhb_pixel_ram import w2dhb_pkg::*; #(
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire q16_t              wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output q16_t                   rdata
);

  q16_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/weighted_2d_histogram_binner_unit.sv
// Top level of the weighted 2-D histogram binner: control, configuration and item channels.
//
// Usage:
//   s_* channel takes one item per handshake; s_tuser holds the opcode (bin, read, write).
//   s_tdata holds, lowest bit first: coord_x, coord_y, weight, pixel_col, pixel_row,
//   write_value. m_* channel returns exactly one item per input item; m_tdata holds
//   result_value, bin_col, bin_row and m_tuser holds hit.
//   Configuration is written through cfg_we/cfg_addr/cfg_data while the block is idle.
// Timing:
//   A bin item goes from accept to the next accept through one subtract, a split
//   17x32 multiply, a wide add with range check, then a read-modify-write of the pixel
//   memory through its registered read port. Read and write items skip the mapping steps.
//   The result is held in an output register, so the next item is accepted while a
//   result still waits; the memory update of that next item waits until the output
//   register is free, so a stalled receiver holds the block in its update step.
// Reset:
//   rst restores the register defaults and starts a clearing pass that writes zero to
//   every pixel, one per cycle, 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) pixels, 65536
//   at the defaults. No item is accepted during the pass; configuration writes are.
`default_nettype none
module weighted_2d_histogram_binner_unit import w2dhb_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // fields: coord_x, coord_y, weight, pixel_col, pixel_row, write_value
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // fields: opcode
  input  wire logic [1:0]            s_tuser,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // fields: result_value, bin_col, bin_row
  output logic [M_TDATA_W-1:0]       m_tdata,
  // fields: hit
  output logic                       m_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [31:0]           cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int AW   = CW + RW;
  localparam int WS_W = $clog2(MAX_WIDTH + 1);
  localparam int HS_W = $clog2(MAX_HEIGHT + 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIFF  = 3'd2;
  localparam logic [2:0] ST_MULT  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_MOD   = 3'd6;

  // Configuration registers
  q16_t       origin_x, origin_y, scale_x, scale_y;
  logic [8:0] image_width, image_height;
  logic       magic_mode, use_weight;

  logic [2:0]    state, state_next;
  logic [AW-1:0] clr_addr;

  // Held item
  logic [1:0] op_q;
  q16_t       cx_q, cy_q, wt_q, wv_q;
  logic [7:0] pcol_q, prow_q;

  // Pixel target, captured in the read step
  logic          hit_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    col8_q, row8_q;

  logic          hit_c;
  logic [AW-1:0] addr_c;
  logic [7:0]    col8_c, row8_c;
  logic [31:0]   pc32, pr32;

  logic [WS_W-1:0] wuse;
  logic [HS_W-1:0] huse;

  logic          mx_in, my_in;
  logic [CW-1:0] mx_idx;
  logic [RW-1:0] my_idx;
  logic [7:0]    mx_low8, my_low8;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  q16_t          ram_wdata, ram_rdata;

  q16_t               new_val, add_val;
  logic               wr_pix;
  logic signed [32:0] sum33;
  logic               out_free, accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Size in use is the register clipped to the store
  assign wuse = (32'(image_width) > 32'(MAX_WIDTH)) ? WS_W'(MAX_WIDTH) : WS_W'(image_width);
  assign huse = (32'(image_height) > 32'(MAX_HEIGHT)) ? HS_W'(MAX_HEIGHT) : HS_W'(image_height);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      scale_x      <= ONE_Q16;
      scale_y      <= ONE_Q16;
      image_width  <= IMAGE_SIZE_RST;
      image_height <= IMAGE_SIZE_RST;
      magic_mode   <= 1'b0;
      use_weight   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X:   origin_x     <= cfg_data;
        REG_ORIGIN_Y:   origin_y     <= cfg_data;
        REG_SCALE_X:    scale_x      <= cfg_data;
        REG_SCALE_Y:    scale_y      <= cfg_data;
        REG_IMAGE_W:    image_width  <= cfg_data[8:0];
        REG_IMAGE_H:    image_height <= cfg_data[8:0];
        REG_MAGIC_MODE: magic_mode   <= cfg_data[0];
        REG_USE_WEIGHT: use_weight   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item for the whole of its processing
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= s_tuser;
      cx_q   <= s_tdata[31:0];
      cy_q   <= s_tdata[63:32];
      wt_q   <= s_tdata[95:64];
      pcol_q <= s_tdata[103:96];
      prow_q <= s_tdata[111:104];
      wv_q   <= s_tdata[143:112];
    end
  end

  w2dhb_axis_map #(.IDX_W(CW), .SZ_W(WS_W)) u_map_x (
    .clk      (clk),
    .coord    (cx_q),
    .origin   (origin_x),
    .scale    (scale_x),
    .size     (wuse),
    .in_range (mx_in),
    .index    (mx_idx),
    .low8     (mx_low8)
  );

  w2dhb_axis_map #(.IDX_W(RW), .SZ_W(HS_W)) u_map_y (
    .clk      (clk),
    .coord    (cy_q),
    .origin   (origin_y),
    .scale    (scale_y),
    .size     (huse),
    .in_range (my_in),
    .index    (my_idx),
    .low8     (my_low8)
  );

  // Pick the pixel: mapped bin for a bin item, direct address for read and write
  always_comb begin
    pc32   = 32'(pcol_q);
    pr32   = 32'(prow_q);
    hit_c  = 1'b0;
    addr_c = '0;
    col8_c = '0;
    row8_c = '0;
    unique case (op_q)
      OP_BIN: begin
        hit_c  = mx_in && my_in;
        addr_c = {my_idx, mx_idx};
        col8_c = mx_low8;
        row8_c = my_low8;
      end
      OP_READ, OP_WRITE: begin
        hit_c  = (pc32 < 32'(wuse)) && (pr32 < 32'(huse));
        addr_c = {pr32[RW-1:0], pc32[CW-1:0]};
        col8_c = pcol_q;
        row8_c = prow_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      hit_q  <= hit_c;
      addr_q <= addr_c;
      col8_q <= col8_c;
      row8_q <= row8_c;
    end
  end

  // Modify step: marker, saturating add, plain read or preload
  always_comb begin
    add_val = use_weight ? wt_q : ONE_Q16;
    sum33   = {ram_rdata[31], ram_rdata} + {add_val[31], add_val};
    new_val = ram_rdata;
    wr_pix  = 1'b0;
    unique case (op_q)
      OP_BIN: begin
        wr_pix = 1'b1;
        priority if (magic_mode || ram_rdata == MARKER_CODE) begin
          new_val = MARKER_CODE;
        end else if (sum33 > 33'(SUM_MAX)) begin
          new_val = SUM_MAX;
        end else if (sum33 < 33'(SUM_MIN)) begin
          new_val = SUM_MIN;
        end else begin
          new_val = sum33[31:0];
        end
      end
      OP_READ: ;
      OP_WRITE: begin
        wr_pix  = 1'b1;
        new_val = wv_q;
      end
      default: ;
    endcase
  end

  // Memory port selection: clearing pass or write-back of the current item
  always_comb begin
    ram_raddr = (state == ST_READ) ? addr_c : addr_q;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == ST_MOD) && out_free && wr_pix && hit_q;
      ram_waddr = addr_q;
      ram_wdata = new_val;
    end
  end

  w2dhb_pixel_ram #(.ADDR_W(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = (s_tuser == OP_BIN) ? ST_DIFF : ST_READ;
      ST_DIFF:  state_next = ST_MULT;
      ST_MULT:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_READ;
      ST_READ:  state_next = ST_MOD;
      ST_MOD:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Output register: load on update, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_MOD && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_MOD && out_free) begin
      m_tuser <= hit_q;
      m_tdata <= hit_q ? {row8_q, col8_q, new_val} : '0;
    end
  end

  // A result only appears out of the update step
  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_MOD))
    else $error("result appeared outside the update step");

  // A missed pixel reports all-zero fields
  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("skipped item carries non-zero fields");

  // Write-back only touches a pixel inside the image
  a_write_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != ST_CLEAR) |-> hit_q)
    else $error("pixel written for an item that missed");

  // The mapper pipeline is walked in order before the pixel is read
  a_map_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIFF) |=> (state == ST_MULT) ##1 (state == ST_SUM) ##1 (state == ST_READ))
    else $error("bin mapping steps out of order");

endmodule
`default_nettype wire
